// ===== hw/rtl/tcsu_pkg.sv =====
// Shared types, widths and register codes of the token channel state update block.
package tcsu_pkg;

    localparam int TOKEN_W      = 6;
    localparam int DRIVE_W      = 3;
    localparam int HLIM_W       = 3;
    localparam int SLIM_W       = 7;
    localparam int AVG_W        = 4;
    localparam int SUM_W        = 8;
    localparam int MAX_W        = 3;
    localparam int CHAN_FIELD_W = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 24;

    localparam int DEFAULT_CHANNELS = 64;
    localparam int DEFAULT_VOCAB    = 8;

    localparam logic [DRIVE_W-1:0] DRIVE_RESET = DRIVE_W'(3);
    localparam logic [HLIM_W-1:0]  HLIM_RESET  = HLIM_W'(4);
    localparam logic [SLIM_W-1:0]  SLIM_RESET  = SLIM_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_LEVEL = 2'd0,
        CFG_H_LIMIT     = 2'd1,
        CFG_S_LIMIT     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_level;
        logic [HLIM_W-1:0]  h_limit;
        logic [SLIM_W-1:0]  s_limit;
    } cfg_t;

    typedef struct packed {
        logic update;
        logic clear;
        logic shift;
    } dp_cmd_t;

endpackage

// ===== hw/rtl/tcsu_cfg.sv =====
// Configuration register file: drive level, h limit and s limit.
module tcsu_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcsu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcsu_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tcsu_pkg::cfg_t                    cfg
);
    import tcsu_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drive_level <= DRIVE_RESET;
            cfg_reg.h_limit     <= HLIM_RESET;
            cfg_reg.s_limit     <= SLIM_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DRIVE_LEVEL: cfg_reg.drive_level <= cfg_data[DRIVE_W-1:0];
                CFG_H_LIMIT:     cfg_reg.h_limit     <= cfg_data[HLIM_W-1:0];
                CFG_S_LIMIT:     cfg_reg.s_limit     <= cfg_data[SLIM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/tcsu_dpath.sv =====
// Per-channel store registers with update lanes and a rotating read-out for the dump.
module tcsu_dpath #(
    parameter int CHANNELS = tcsu_pkg::DEFAULT_CHANNELS,
    parameter int VOCAB    = tcsu_pkg::DEFAULT_VOCAB
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tcsu_pkg::dp_cmd_t                     cmd,
    input  tcsu_pkg::cfg_t                        cfg,
    input  logic [tcsu_pkg::TOKEN_W-1:0]          token,
    output logic signed [tcsu_pkg::AVG_W-1:0]     head_avg,
    output logic signed [tcsu_pkg::SUM_W-1:0]     head_sum,
    output logic [tcsu_pkg::MAX_W-1:0]            head_max
);
    import tcsu_pkg::*;

    logic signed [AVG_W-1:0] avg_reg [CHANNELS];
    logic signed [SUM_W-1:0] sum_reg [CHANNELS];
    logic [MAX_W-1:0]        max_reg [CHANNELS];

    logic                 tok_ok;
    logic signed [AVG_W:0] hl_s;
    logic signed [SUM_W:0] sl_s;

    assign tok_ok = (7'(token) < 7'(VOCAB));
    assign hl_s   = (AVG_W+1)'({1'b0, cfg.h_limit});
    assign sl_s   = (SUM_W+1)'({1'b0, cfg.s_limit});

    assign head_avg = avg_reg[0];
    assign head_sum = sum_reg[0];
    assign head_max = max_reg[0];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        localparam int NXT = (c + 1) % CHANNELS;

        logic                    hit;
        logic [DRIVE_W-1:0]      x;
        logic signed [AVG_W-1:0] avg_base;
        logic signed [SUM_W-1:0] sum_base;
        logic [MAX_W-1:0]        max_base;
        logic signed [AVG_W:0]   avg_t;
        logic signed [AVG_W:0]   avg_half;
        logic signed [SUM_W:0]   sum_t;
        logic [MAX_W-1:0]        max_t;
        logic signed [AVG_W-1:0] avg_next;
        logic signed [SUM_W-1:0] sum_next;
        logic [MAX_W-1:0]        max_next;

        if (c < (1 << TOKEN_W)) begin : g_hit
            assign hit = tok_ok && (token == TOKEN_W'(c));
        end else begin : g_nohit
            assign hit = 1'b0;
        end

        always_comb begin
            x        = hit ? cfg.drive_level : '0;
            avg_base = cmd.clear ? '0 : avg_reg[c];
            sum_base = cmd.clear ? '0 : sum_reg[c];
            max_base = cmd.clear ? '0 : max_reg[c];

            // half-sum, rounded half away from zero
            avg_t = {avg_base[AVG_W-1], avg_base} + $signed((AVG_W+1)'(x));
            if (avg_t[AVG_W]) avg_half = avg_t >>> 1;
            else              avg_half = (avg_t + (AVG_W+1)'(1)) >>> 1;
            if (avg_half > hl_s)       avg_next = AVG_W'(hl_s);
            else if (avg_half < -hl_s) avg_next = AVG_W'(-hl_s);
            else                       avg_next = AVG_W'(avg_half);

            sum_t = {sum_base[SUM_W-1], sum_base} + $signed((SUM_W+1)'(x));
            if (sum_t > sl_s)       sum_next = SUM_W'(sl_s);
            else if (sum_t < -sl_s) sum_next = SUM_W'(-sl_s);
            else                    sum_next = SUM_W'(sum_t);

            max_t    = (max_base > x) ? max_base : x;
            max_next = (max_t > cfg.h_limit) ? cfg.h_limit : max_t;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                avg_reg[c] <= '0;
                sum_reg[c] <= '0;
                max_reg[c] <= '0;
            end else if (cmd.update) begin
                avg_reg[c] <= avg_next;
                sum_reg[c] <= sum_next;
                max_reg[c] <= max_next;
            end else if (cmd.shift) begin
                avg_reg[c] <= avg_reg[NXT];
                sum_reg[c] <= sum_reg[NXT];
                max_reg[c] <= max_reg[NXT];
            end
        end
    end

endmodule

// ===== hw/rtl/tcsu_ctrl.sv =====
// Controller: accepts tokens, sequences the per-channel dump beats.
module tcsu_ctrl #(
    parameter int CHANNELS = tcsu_pkg::DEFAULT_CHANNELS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic                                  s_tuser,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [tcsu_pkg::CHAN_FIELD_W-1:0]     channel,
    output logic                                  end_of_dump,
    output tcsu_pkg::dp_cmd_t                     cmd
);
    import tcsu_pkg::*;

    localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CNT_W-1:0] LAST_CH = CNT_W'(CHANNELS - 1);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             s_tready_reg;
    logic             m_tvalid_reg;
    logic             s_fire;
    logic             m_fire;

    assign s_tready    = s_tready_reg;
    assign m_tvalid    = m_tvalid_reg;
    assign s_fire      = s_tvalid && s_tready_reg;
    assign m_fire      = m_tvalid_reg && m_tready;
    assign channel     = CHAN_FIELD_W'(cnt_reg);
    assign end_of_dump = (cnt_reg == LAST_CH);

    assign cmd.update = s_fire;
    assign cmd.clear  = s_fire && s_tuser;
    assign cmd.shift  = m_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_tlast) begin
                        state_reg    <= ST_DUMP;
                        cnt_reg      <= '0;
                        s_tready_reg <= 1'b0;
                        m_tvalid_reg <= 1'b1;
                    end
                end
                ST_DUMP: begin
                    if (m_fire) begin
                        if (cnt_reg == LAST_CH) begin
                            state_reg    <= ST_IDLE;
                            cnt_reg      <= '0;
                            s_tready_reg <= 1'b1;
                            m_tvalid_reg <= 1'b0;
                        end else begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted during dump");

    a_dump_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (m_tvalid && (cnt_reg == '0)))
        else $error("dump did not start at channel zero");

    a_dump_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && end_of_dump) |=> (s_tready && !m_tvalid))
        else $error("controller did not return to idle after final beat");

    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0))
        else $error("channel counter nonzero while idle");
`endif

endmodule

// ===== hw/rtl/token_channel_state_update.sv =====
// Top level of the token channel state update block.
// Usage:
//   s_ channel: one beat per token. s_tdata[5:0] token, s_tuser first (clear all
//   channel stores before the token), s_tlast last (report all channels after it).
//   cfg channel: cfg_index selects drive_level (0), h_limit (1), s_limit (2);
//   cfg_ready is always high. Write only while no dump is in progress.
//   m_ channel: one beat per channel, channel 0 first, m_tlast on channel CHANNELS-1.
// Throughput:
//   A token without last is absorbed into the stores; a new token can follow every cycle.
//   All CHANNELS lanes update in parallel when the token is accepted.
//   A token with last starts the dump in the next cycle; the dump takes CHANNELS
//   beats, one per cycle when m_tready is high, and s_tready is low throughout.
//   The dump rotates the store registers, so the current channel is always in register 0 at the output.
// Reset: aresetn low clears all stores to zero, loads register defaults
//   (drive 3, h limit 4, s limit 64) and leaves the block idle with s_tready high.
// Stall: with m_tready low the current beat holds and the dump simply pauses.
module token_channel_state_update #(
    parameter int CHANNELS = tcsu_pkg::DEFAULT_CHANNELS,
    parameter int VOCAB    = tcsu_pkg::DEFAULT_VOCAB
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [tcsu_pkg::S_TDATA_W-1:0]        s_tdata,  // token[5:0], zero[7:6]
    input  logic                                  s_tuser,  // first
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // channel[5:0], avg_value[9:6], sum_value[17:10], max_value[20:18], zero[23:21]
    output logic [tcsu_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast,  // end_of_dump
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tcsu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tcsu_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tcsu_pkg::*;

    cfg_t                    cfg;
    dp_cmd_t                 cmd;
    logic [CHAN_FIELD_W-1:0] channel;
    logic signed [AVG_W-1:0] head_avg;
    logic signed [SUM_W-1:0] head_sum;
    logic [MAX_W-1:0]        head_max;

    tcsu_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcsu_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .channel     (channel),
        .end_of_dump (m_tlast),
        .cmd         (cmd)
    );

    tcsu_dpath #(
        .CHANNELS (CHANNELS),
        .VOCAB    (VOCAB)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .token    (s_tdata[TOKEN_W-1:0]),
        .head_avg (head_avg),
        .head_sum (head_sum),
        .head_max (head_max)
    );

    assign m_tdata = {3'b000, head_max, head_sum, head_avg, channel};

endmodule
